### hdl/tsp_pkg.sv
// Types, character constants and helper functions of the time sentence parser.
package tsp_pkg;

    typedef enum logic [3:0] {
        PH_HUNT    = 4'd0,
        PH_HDR1    = 4'd1,
        PH_HDR2    = 4'd2,
        PH_HDR3    = 4'd3,
        PH_HDR4    = 4'd4,
        PH_HDR5    = 4'd5,
        PH_HDR6    = 4'd6,
        PH_PAYLOAD = 4'd7,
        PH_CHECK   = 4'd8
    } phase_t;

    localparam int unsigned CHECK_CHARS = 2;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_P      = 8'h50;
    localparam logic [7:0] CH_D      = 8'h44;
    localparam logic [7:0] CH_T      = 8'h54;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DIG_LO = 8'h30;
    localparam logic [7:0] CH_DIG_HI = 8'h39;
    localparam logic [7:0] CH_HEX_LO = 8'h41;
    localparam logic [7:0] CH_HEX_HI = 8'h46;
    localparam logic [7:0] HEX_ALPHA_OFS = 8'h37;

    // XOR over "PDT,1," seeds the payload checksum
    localparam logic [7:0] XOR_HDR_SEED = CH_P ^ CH_D ^ CH_T ^ CH_COMMA ^ CH_ONE ^ CH_COMMA;

    typedef struct packed {
        phase_t      phase;
        logic [7:0]  xor_sum;
        logic        xor_stopped;
        logic [7:0]  rx_check;
        logic [31:0] time_shift;
        logic [31:0] good_time;
    } tsp_state_t;

    typedef struct packed {
        logic done;
        logic ok;
    } tsp_flags_t;

    function automatic logic [3:0] hex_nibble(input logic [7:0] b);
        logic [7:0] diff;
        begin
            diff = b - HEX_ALPHA_OFS;
            if (b >= CH_DIG_LO && b <= CH_DIG_HI)
                hex_nibble = b[3:0];
            else if (b >= CH_HEX_LO && b <= CH_HEX_HI)
                hex_nibble = diff[3:0];
            else
                hex_nibble = 4'd0;
        end
    endfunction

    function automatic logic [7:0] hdr_char(input phase_t ph);
        begin
            unique case (ph)
                PH_HDR1: hdr_char = CH_P;
                PH_HDR2: hdr_char = CH_D;
                PH_HDR3: hdr_char = CH_T;
                PH_HDR4: hdr_char = CH_COMMA;
                PH_HDR5: hdr_char = CH_ONE;
                PH_HDR6: hdr_char = CH_COMMA;
                default: hdr_char = CH_DOLLAR;
            endcase
        end
    endfunction

    function automatic phase_t hdr_succ(input phase_t ph);
        begin
            unique case (ph)
                PH_HDR1: hdr_succ = PH_HDR2;
                PH_HDR2: hdr_succ = PH_HDR3;
                PH_HDR3: hdr_succ = PH_HDR4;
                PH_HDR4: hdr_succ = PH_HDR5;
                PH_HDR5: hdr_succ = PH_HDR6;
                default: hdr_succ = PH_HUNT;
            endcase
        end
    endfunction

endpackage

### hdl/tsp_if.sv
// Handshake interfaces for received bytes and parse results.
interface tsp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface tsp_out_if;
    logic        valid;
    logic        ready;
    logic        frame_done;
    logic        checksum_ok;
    logic [31:0] time_value;

    modport source (output valid, output frame_done, output checksum_ok,
                    output time_value, input ready);
    modport sink   (input valid, input frame_done, input checksum_ok,
                    input time_value, output ready);
endinterface

### hdl/tsp_step.sv
// Single-byte parse step: next parser state and frame flags.
module tsp_step
    import tsp_pkg::*;
#(
    parameter int unsigned PAYLOAD_CHARS = 8,
    parameter int unsigned CNT_W         = 4
)(
    input  logic [7:0]       rx_byte,
    input  tsp_state_t       cur,
    input  logic [CNT_W-1:0] cnt,
    output tsp_state_t       nxt,
    output logic [CNT_W-1:0] cnt_next,
    output tsp_flags_t       flags
);

    logic [3:0] nib;
    logic       stop;

    always_comb
    begin
        nxt      = cur;
        cnt_next = cnt;
        flags    = '0;
        nib      = hex_nibble(rx_byte);
        stop     = cur.xor_stopped || (rx_byte == CH_STAR);

        unique case (cur.phase) inside
            PH_HDR1, PH_HDR2, PH_HDR3, PH_HDR4, PH_HDR5, PH_HDR6:
            begin
                if (rx_byte != hdr_char(cur.phase))
                    nxt.phase = PH_HUNT;
                else if (cur.phase == PH_HDR6)
                begin
                    nxt.phase       = PH_PAYLOAD;
                    cnt_next        = '0;
                    nxt.xor_sum     = XOR_HDR_SEED;
                    nxt.xor_stopped = 1'b0;
                    nxt.time_shift  = '0;
                end
                else
                    nxt.phase = hdr_succ(cur.phase);
            end
            PH_PAYLOAD:
            begin
                if (cnt < CNT_W'(PAYLOAD_CHARS))
                begin
                    nxt.xor_stopped = stop;
                    if (!stop)
                        nxt.xor_sum = cur.xor_sum ^ rx_byte;
                    nxt.time_shift = {cur.time_shift[27:0], nib};
                    cnt_next       = cnt + CNT_W'(1);
                end
                else if (rx_byte == CH_STAR)
                begin
                    nxt.phase    = PH_CHECK;
                    cnt_next     = '0;
                    nxt.rx_check = '0;
                end
                else
                begin
                    // no star: restart payload, header stays matched
                    cnt_next        = '0;
                    nxt.xor_sum     = XOR_HDR_SEED;
                    nxt.xor_stopped = 1'b0;
                    nxt.time_shift  = '0;
                end
            end
            PH_CHECK:
            begin
                if (cnt < CNT_W'(CHECK_CHARS))
                begin
                    nxt.rx_check = {cur.rx_check[3:0], nib};
                    cnt_next     = cnt + CNT_W'(1);
                end
                else
                begin
                    flags.done = 1'b1;
                    if (cur.rx_check == cur.xor_sum)
                    begin
                        flags.ok      = 1'b1;
                        nxt.good_time = cur.time_shift;
                    end
                    cnt_next  = '0;
                    nxt.phase = PH_HUNT;
                end
            end
            default:
                nxt.phase = (rx_byte == CH_DOLLAR) ? PH_HDR1 : PH_HUNT;
        endcase
    end

endmodule

### hdl/time_sentence_parser.sv
// Time sentence parser top level: input register, parse step, result register.
// The parse step is one pass of logic between the input register and the result register.
// Throughput: one byte per cycle while the result register is not stalled.
// Backpressure stalls the input register; a new byte is taken while a result is taken.
// Reset (rst_n low, asynchronous) clears both valid flags and all parser state;
// time_value reads zero until a sentence with a matching checksum closes.
module time_sentence_parser
    import tsp_pkg::*;
#(
    parameter int unsigned PAYLOAD_CHARS = 8
)(
    input  logic      clk,
    input  logic      rst_n,
    tsp_in_if.sink    rx,
    tsp_out_if.source res
);

    localparam int unsigned CNT_MAX = (PAYLOAD_CHARS > CHECK_CHARS) ? PAYLOAD_CHARS
                                                                     : CHECK_CHARS;
    localparam int unsigned CNT_W   = $clog2(CNT_MAX + 1);

    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;
    tsp_state_t       state_reg;
    tsp_state_t       state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    tsp_flags_t       step_flags;
    logic             out_valid_reg;
    logic             out_done_reg;
    logic             out_ok_reg;
    logic             advance;
    logic             load;

    assign advance  = !out_valid_reg || res.ready;
    assign load     = in_valid_reg && advance;
    assign rx.ready = !in_valid_reg || advance;

    tsp_step #(
        .PAYLOAD_CHARS (PAYLOAD_CHARS),
        .CNT_W         (CNT_W)
    ) u_step (
        .rx_byte  (in_byte_reg),
        .cur      (state_reg),
        .cnt      (cnt_reg),
        .nxt      (state_next),
        .cnt_next (cnt_next),
        .flags    (step_flags)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (rx.valid && rx.ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (load)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
            in_byte_reg <= rx.rx_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '{phase: PH_HUNT, default: '0};
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_done_reg  <= 1'b0;
            out_ok_reg    <= 1'b0;
        end
        else if (load)
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= 1'b1;
            out_done_reg  <= step_flags.done;
            out_ok_reg    <= step_flags.ok;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // good_time only moves on a load, which also replaces the held result
    assign res.valid       = out_valid_reg;
    assign res.frame_done  = out_done_reg;
    assign res.checksum_ok = out_ok_reg;
    assign res.time_value  = state_reg.good_time;

`ifndef ASSERT_OFF
    a_ok_implies_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_ok_reg |-> out_done_reg)
        else $error("checksum_ok without frame_done");

    a_good_time_capture: assert property (@(posedge clk) disable iff (!rst_n)
        load && step_flags.done && step_flags.ok
        |=> state_reg.good_time == $past(state_reg.time_shift))
        else $error("good time not taken from captured payload");

    a_good_time_hold: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.good_time != $past(state_reg.good_time) |-> out_valid_reg && out_ok_reg)
        else $error("good time changed without a matching checksum");

    a_payload_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase == PH_PAYLOAD |-> cnt_reg <= CNT_W'(PAYLOAD_CHARS))
        else $error("payload count overrun");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> rx.ready)
        else $error("input stalled with empty result register");
`endif

endmodule
